[sv/ilir_pkg.sv]
`timescale 1ns / 1ps
// Package for the indexed list: request codes, status codes, cell control and beat types.
// Depends on nothing; the cell and the top level import it.
package ilir_pkg;

    localparam int ITEM_W  = 64;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 6;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_REMOVE = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [ITEM_W-1:0]   item;
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [POS_W-1:0]    position;
        logic [ITEM_W-1:0]   item_in;
    } req_beat_t;

    typedef struct packed {
        logic [ITEM_W-1:0]   item_out;
        logic [1:0]          status;
        logic [COUNT_W-1:0]  count;
    } res_beat_t;

endpackage

[sv/ilir_cell.sv]
`timescale 1ns / 1ps
// One list cell: holds the entry at a fixed position and shifts with its neighbours.
// Depends on ilir_pkg.
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 6
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [PW-1:0]     position,
    input  logic [ITEM_W-1:0] left,
    input  logic [ITEM_W-1:0] right,
    output logic [ITEM_W-1:0] value,
    output logic [ITEM_W-1:0] rd
);

    localparam logic [PW-1:0] IDX_V = PW'(IDX);

    logic [ITEM_W-1:0] value_reg;
    logic [ITEM_W-1:0] value_next;
    logic              hit;
    logic              above;

    assign hit   = (position == IDX_V);
    assign above = (IDX_V > position);

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            CELL_WRITE:
            begin
                if (hit)
                begin
                    value_next = ctrl.item;
                end
            end
            CELL_INSERT:
            begin
                if (hit)
                begin
                    value_next = ctrl.item;
                end
                else if (above)
                begin
                    value_next = left;
                end
            end
            CELL_REMOVE:
            begin
                if (hit || above)
                begin
                    value_next = right;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign rd    = hit ? value_reg : '0;

endmodule

[sv/indexed_list_insert_remove.sv]
`timescale 1ns / 1ps
// Indexed list of up to DEPTH 64-bit handles held in a row of shifting cells.
// The result beat appears with done in the cycle after start.
// Throughput is one request per cycle; every cell shifts or keeps its entry in that cycle.
// busy stays low, and the receiver cannot stall the result beat.
// Reset clears the entry count and done; cell contents are undefined until written.
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  req_beat_t req,
    output logic      done,
    output res_beat_t result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [PW-1:0] DEPTH_V = PW'(DEPTH);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              done_reg;
    res_beat_t         result_reg;
    res_beat_t         result_next;

    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     cnt_ext;
    logic [PW-1:0]     cnt_after;
    logic              accept;
    logic              is_ins;
    logic              range_err;
    logic              full_err;
    logic              ok;
    cell_ctrl_t        ctrl;
    logic [ITEM_W-1:0] rd_all;

    logic [ITEM_W-1:0] vals   [DEPTH];
    logic [ITEM_W-1:0] rds    [DEPTH];
    logic [ITEM_W-1:0] lefts  [DEPTH];
    logic [ITEM_W-1:0] rights [DEPTH];

    assign accept    = start && !busy;
    assign busy      = 1'b0;
    assign pos_ext   = PW'(req.position);
    assign cnt_ext   = PW'(count_reg);
    assign is_ins    = (req.req_type == REQ_INSERT);
    assign range_err = is_ins ? (pos_ext > cnt_ext) : (pos_ext >= cnt_ext);
    assign full_err  = is_ins && !range_err && (cnt_ext == DEPTH_V);
    assign ok        = accept && !range_err && !full_err;

    always_comb
    begin
        ctrl.item = req.item_in;
        ctrl.op   = CELL_HOLD;
        if (ok)
        begin
            case (req.req_type)
                REQ_WRITE:  ctrl.op = CELL_WRITE;
                REQ_INSERT: ctrl.op = CELL_INSERT;
                REQ_REMOVE: ctrl.op = CELL_REMOVE;
                default:    ctrl.op = CELL_HOLD;
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                assign lefts[k] = '0;
            end
            else
            begin : g_mid_l
                assign lefts[k] = vals[k-1];
            end
            if (k == DEPTH - 1)
            begin : g_last
                assign rights[k] = vals[k];
            end
            else
            begin : g_mid_r
                assign rights[k] = vals[k+1];
            end

            ilir_cell #(
                .IDX (k),
                .PW  (PW)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .position (pos_ext),
                .left     (lefts[k]),
                .right    (rights[k]),
                .value    (vals[k]),
                .rd       (rds[k])
            );
        end
    endgenerate

    always_comb
    begin
        rd_all = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_all = rd_all | rds[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ok && is_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ok && (req.req_type == REQ_REMOVE))
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign cnt_after = PW'(count_next);

    always_comb
    begin
        result_next.count    = cnt_after[COUNT_W-1:0];
        result_next.item_out = (ok && !is_ins) ? rd_all : '0;
        if (range_err)
        begin
            result_next.status = ST_RANGE;
        end
        else if (full_err)
        begin
            result_next.status = ST_FULL;
        end
        else
        begin
            result_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("done did not follow an accepted request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("done without an accepted request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        PW'(count_reg) <= DEPTH_V)
        else $error("entry count exceeds DEPTH");

    a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (range_err || full_err)) |=>
            (count_reg == $past(count_reg)) && (result.item_out == '0))
        else $error("failed request changed the count or returned an item");

endmodule

[verif/indexed_list_checker.sv]
`timescale 1ns / 1ps
// Checker for the indexed list: watches request and result beats, predicts each result
// and compares it field by field. Depends on ilir_pkg for the beat types and codes.
module indexed_list_checker
    import ilir_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  req_beat_t   req,
    input  logic        done,
    input  res_beat_t   result,
    output int unsigned fault_count,
    output int unsigned pending_results
);

    logic [ITEM_W-1:0] list_mem [DEPTH];
    int unsigned       list_len;
    res_beat_t         expected_q [$];
    int unsigned       fault_tally;

    function automatic res_beat_t apply_request(input req_beat_t r);
        res_beat_t   o;
        int unsigned p;
        int unsigned k;
        o = '0;
        p = 32'(r.position);
        if (req_kind_t'(r.req_type) == REQ_INSERT)
        begin
            if (p > list_len)
            begin
                o.status = ST_RANGE;
            end
            else if (list_len >= DEPTH)
            begin
                o.status = ST_FULL;
            end
            else
            begin
                for (k = list_len; k > p; k--)
                begin
                    list_mem[k] = list_mem[k - 1];
                end
                list_mem[p] = r.item_in;
                list_len++;
                o.status = ST_OK;
            end
        end
        else if (p >= list_len)
        begin
            o.status = ST_RANGE;
        end
        else
        begin
            o.item_out = list_mem[p];
            o.status = ST_OK;
            case (req_kind_t'(r.req_type))
                REQ_WRITE:
                begin
                    list_mem[p] = r.item_in;
                end
                REQ_REMOVE:
                begin
                    for (k = p; k + 1 < list_len; k++)
                    begin
                        list_mem[k] = list_mem[k + 1];
                    end
                    list_len--;
                end
                default:
                begin
                end
            endcase
        end
        o.count = list_len[COUNT_W-1:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_beat_t want;
        if (!rst_n)
        begin
            list_len = 0;
            expected_q.delete();
            fault_tally = 0;
            fault_count <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_q.push_back(apply_request(req));
            end
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    fault_tally++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result.item_out !== want.item_out)
                    begin
                        $error("item_out: expected %h, actual %h", want.item_out,
                               result.item_out);
                        fault_tally++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, result.status);
                        fault_tally++;
                    end
                    if (result.count !== want.count)
                    begin
                        $error("count: expected %0d, actual %0d", want.count, result.count);
                        fault_tally++;
                    end
                end
            end
            fault_count <= fault_tally;
            pending_results <= expected_q.size();
        end
    end

endmodule

[verif/indexed_list_insert_remove_tb.sv]
`timescale 1ns / 1ps
// Top of the indexed list testbench: clock, reset, directed and random request beats.
// Depends on ilir_pkg, indexed_list_insert_remove and indexed_list_checker.
module indexed_list_insert_remove_tb;
    import ilir_pkg::*;

    localparam int          LIST_DEPTH   = 32;
    localparam int unsigned RANDOM_ITEMS = 1650;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_beat_t   req;
    logic        done;
    res_beat_t   result;
    int unsigned fault_count;
    int unsigned pending_results;
    int unsigned fill_level;

    indexed_list_insert_remove #(.DEPTH(LIST_DEPTH)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    indexed_list_checker #(.DEPTH(LIST_DEPTH)) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req             (req),
        .done            (done),
        .result          (result),
        .fault_count     (fault_count),
        .pending_results (pending_results)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic send_beat(input req_beat_t b);
        start <= 1'b1;
        req <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (req_kind_t'(b.req_type) == REQ_INSERT)
        begin
            if (32'(b.position) <= fill_level && fill_level < LIST_DEPTH) fill_level++;
        end
        else if (req_kind_t'(b.req_type) == REQ_REMOVE && 32'(b.position) < fill_level)
        begin
            fill_level--;
        end
    endtask

    task automatic issue(input req_kind_t kind, input int unsigned pos,
                         input logic [ITEM_W-1:0] item);
        req_beat_t b;
        b.req_type = kind;
        b.position = pos[POS_W-1:0];
        b.item_in = item;
        send_beat(b);
    endtask

    task automatic idle_cycles(input int unsigned n);
        if (n != 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    function automatic req_beat_t pick_request(input mix_t mix);
        req_beat_t   b;
        int unsigned roll;
        int unsigned ins_pct;
        int unsigned rem_pct;
        b.item_in = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            b.req_type = 2'($urandom_range(3));
            b.position = POS_W'($urandom_range(63));
            return b;
        end
        case (mix)
            MIX_FILL:
            begin
                ins_pct = 60;
                rem_pct = 15;
            end
            MIX_DRAIN:
            begin
                ins_pct = 15;
                rem_pct = 60;
            end
            default:
            begin
                ins_pct = 25;
                rem_pct = 25;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < ins_pct)
        begin
            b.req_type = REQ_INSERT;
        end
        else if (roll < ins_pct + rem_pct)
        begin
            b.req_type = REQ_REMOVE;
        end
        else
        begin
            b.req_type = ($urandom_range(1) == 0) ? REQ_READ : REQ_WRITE;
        end
        if (req_kind_t'(b.req_type) == REQ_INSERT)
        begin
            b.position = POS_W'($urandom_range(fill_level));
        end
        else if (fill_level == 0 || $urandom_range(19) == 0)
        begin
            b.position = POS_W'(fill_level);
        end
        else
        begin
            b.position = POS_W'($urandom_range(fill_level - 1));
        end
        return b;
    endfunction

    initial
    begin
        mix_t        mix;
        int unsigned sent;
        int unsigned phase_len;
        int unsigned max_gap;
        int unsigned burst_left;
        int unsigned guard;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        fill_level = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(REQ_READ, 0, 64'h0);
        issue(REQ_WRITE, 0, '1);
        issue(REQ_REMOVE, 0, 64'h0);
        issue(REQ_INSERT, 1, 64'h1);
        issue(REQ_INSERT, 63, '1);
        issue(REQ_INSERT, 0, '1);
        issue(REQ_INSERT, 0, 64'h0);
        issue(REQ_INSERT, 2, 64'hAAAA_AAAA_AAAA_AAAA);
        issue(REQ_INSERT, 1, 64'h5555_5555_5555_5555);
        issue(REQ_READ, 0, 64'h0);
        issue(REQ_READ, 3, 64'h0);
        issue(REQ_READ, 4, 64'h0);
        issue(REQ_READ, 63, '1);
        issue(REQ_WRITE, 2, 64'h0123_4567_89AB_CDEF);
        issue(REQ_WRITE, 4, 64'hFEDC_BA98_7654_3210);
        issue(REQ_REMOVE, 1, 64'h0);
        issue(REQ_REMOVE, 2, 64'h0);
        issue(REQ_REMOVE, 3, 64'h0);
        issue(REQ_READ, 1, 64'h0);
        issue(REQ_REMOVE, 0, 64'h0);
        issue(REQ_REMOVE, 0, 64'h0);
        issue(REQ_REMOVE, 0, '1);
        issue(REQ_INSERT, 32, 64'h0);
        wait_all_results();

        sent = 0;
        burst_left = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mix = mix_t'($urandom_range(2));
            phase_len = $urandom_range(40, 120);
            max_gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            for (int unsigned i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                if (burst_left == 0)
                begin
                    idle_cycles($urandom_range(max_gap));
                    burst_left = $urandom_range(1, 20);
                end
                send_beat(pick_request(mix));
                burst_left--;
                sent++;
                if (sent == RANDOM_ITEMS / 2) wait_all_results();
            end
        end

        start <= 1'b0;
        guard = 0;
        while (pending_results != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (fault_count == 0 && pending_results == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
